@@ src/rnbc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rnbc_pkg
// shared types and constants of the response norm bound check
// ----------------------------------------------------------------------------
package rnbc_pkg;

	localparam int COEFF_W  = 12;
	localparam int INF_W    = 11;
	localparam int L2_W     = 16;
	localparam int SUMSQ_W  = 32;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic [INF_W-1:0]   MAX_CLAMP     = 11'd2047;
	localparam logic [SUMSQ_W-1:0] SUMSQ_SAT     = 32'hFFFF_FFFF;
	localparam logic [INF_W-1:0]   INF_BOUND_RST = 11'd1664;
	localparam logic [L2_W-1:0]    L2_MIN_RST    = 16'd0;

	// register index taken from paddr[2]
	localparam logic REG_INF_BOUND = 1'b0;
	localparam logic REG_L2_MIN    = 1'b1;

	typedef struct packed {
		logic [COEFF_W-1:0] resp_coeff;
		logic [COEFF_W-1:0] mask_coeff;
		logic               last;
	} coeff_t;

	typedef struct packed {
		logic               verdict;
		logic               inf_exceeded;
		logic               l2_too_small;
		logic [INF_W-1:0]   max_abs;
		logic [SUMSQ_W-1:0] sum_squares;
	} result_t;

endpackage

`default_nettype wire

@@ src/rnbc_reduce.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rnbc_reduce
// two-stage reduction of a 12-bit coefficient mod MODULUS by reciprocal multiply
// ----------------------------------------------------------------------------
module rnbc_reduce #(
	parameter int MODULUS = 3329
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [rnbc_pkg::COEFF_W-1:0] x,
	output logic [((MODULUS <= 4096) ? $clog2(MODULUS) : rnbc_pkg::COEFF_W)-1:0] r
);

	localparam int R_W    = (MODULUS <= 4096) ? $clog2(MODULUS) : rnbc_pkg::COEFF_W;
	localparam int SHIFT  = 28;
	localparam int QMAX   = 4095 / MODULUS;
	localparam int QT_W   = (QMAX > 0) ? $clog2(QMAX + 1) : 1;
	localparam int PROD_W = SHIFT + rnbc_pkg::COEFF_W;
	localparam logic [SHIFT-1:0] RECIP =
		SHIFT'(((longint'(1) << SHIFT) + longint'(MODULUS) - 1) / longint'(MODULUS));

	logic [PROD_W-1:0]             prod;
	logic [QT_W-1:0]               quot;
	logic [QT_W-1:0]               quot_s2;
	logic [rnbc_pkg::COEFF_W-1:0]  x_s2;
	logic [SHIFT-1:0]              back;
	logic [rnbc_pkg::COEFF_W-1:0]  rem;

	// quotient is exact for 12-bit inputs with a 28-bit reciprocal
	assign prod = PROD_W'(x) * PROD_W'(RECIP);
	assign quot = QT_W'(prod >> SHIFT);

	always_ff @(posedge clk) begin
		if (en) begin
			quot_s2 <= quot;
			x_s2    <= x;
		end
	end

	assign back = SHIFT'(quot_s2) * SHIFT'(MODULUS);
	assign rem  = x_s2 - rnbc_pkg::COEFF_W'(back);

	always_ff @(posedge clk) begin
		if (en) begin
			r <= R_W'(rem);
		end
	end

endmodule

`default_nettype wire

@@ src/response_norm_bound_check.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// response_norm_bound_check
// lifts (resp - mask) mod q, tracks max abs and saturating sum of squares,
// checks both norms on the last beat of a vector
// ----------------------------------------------------------------------------
// result path: the last beat passes stages s1 to s5, then the result register sets result valid
// throughput: one coefficient beat per cycle; a five-stage pipeline plus
//   the result register, input stalls only when a finished result is held
//   and the next last beat reaches the accumulator
// reset: clears pipeline valids, running max and sum, result valid, and
//   loads inf_bound = 1664, l2_min = 0
// ----------------------------------------------------------------------------
module response_norm_bound_check #(
	parameter int MODULUS = 3329
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          coeff_valid,
	output logic                               coeff_ready,
	input  wire rnbc_pkg::coeff_t              coeff,
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output rnbc_pkg::result_t                  result,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [rnbc_pkg::APB_AW-1:0]   paddr,
	input  wire logic [rnbc_pkg::APB_DW-1:0]   pwdata,
	output logic [rnbc_pkg::APB_DW-1:0]        prdata,
	output logic                               pready
);

	localparam int R_W  = (MODULUS <= 4096) ? $clog2(MODULUS) : rnbc_pkg::COEFF_W;
	localparam int D_W  = $clog2(MODULUS) + 1;
	localparam int A_W  = $clog2(MODULUS / 2 + 1);
	localparam int SQ_W = 2 * A_W;
	localparam logic [D_W-1:0] QV   = D_W'(MODULUS);
	localparam logic [D_W-1:0] HALF = D_W'(MODULUS / 2);

	// config
	logic [rnbc_pkg::INF_W-1:0]   inf_bound_q;
	logic [rnbc_pkg::L2_W-1:0]    l2_min_q;
	logic [rnbc_pkg::SUMSQ_W-1:0] l2_sq_q;
	logic                         cfg_wr;

	// pipeline
	logic                           adv;
	logic                           v_s1, v_s2, v_s3, v_s4, v_s5;
	logic                           last_s2, last_s3, last_s4, last_s5;
	rnbc_pkg::coeff_t               coeff_s1;
	logic [R_W-1:0]                 r_s3, m_s3;
	logic [D_W-1:0]                 diff;
	logic [D_W-1:0]                 absv;
	logic [A_W-1:0]                 a_s4;
	logic [SQ_W-1:0]                sq_s5;
	logic [rnbc_pkg::INF_W-1:0]     amax_s5;
	logic [15:0]                    a_ext;

	// accumulator
	logic [rnbc_pkg::INF_W-1:0]     max_q, new_max;
	logic [rnbc_pkg::SUMSQ_W-1:0]   sumsq_q, new_sum;
	logic [rnbc_pkg::SUMSQ_W:0]     sum_wide;
	logic                           inf_ex, l2_small;
	logic                           result_valid_q;
	rnbc_pkg::result_t              result_q;

	// apb
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inf_bound_q <= rnbc_pkg::INF_BOUND_RST;
			l2_min_q    <= rnbc_pkg::L2_MIN_RST;
			l2_sq_q     <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				rnbc_pkg::REG_INF_BOUND: begin
					inf_bound_q <= pwdata[rnbc_pkg::INF_W-1:0];
				end
				rnbc_pkg::REG_L2_MIN: begin
					l2_min_q <= pwdata[rnbc_pkg::L2_W-1:0];
					l2_sq_q  <= rnbc_pkg::SUMSQ_W'(pwdata[rnbc_pkg::L2_W-1:0])
						* rnbc_pkg::SUMSQ_W'(pwdata[rnbc_pkg::L2_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			rnbc_pkg::REG_INF_BOUND: prdata = rnbc_pkg::APB_DW'(inf_bound_q);
			rnbc_pkg::REG_L2_MIN:    prdata = rnbc_pkg::APB_DW'(l2_min_q);
			default:                 prdata = '0;
		endcase
	end

	// stall only when a last beat must land on a held result
	assign adv         = !(v_s5 && last_s5 && result_valid_q && !result_ready);
	assign coeff_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= coeff_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coeff_s1 <= coeff;
			last_s2  <= coeff_s1.last;
			last_s3  <= last_s2;
			last_s4  <= last_s3;
			last_s5  <= last_s4;
		end
	end

	rnbc_reduce #(.MODULUS(MODULUS)) u_reduce_resp (
		.clk (clk),
		.en  (adv),
		.x   (coeff_s1.resp_coeff),
		.r   (r_s3)
	);

	rnbc_reduce #(.MODULUS(MODULUS)) u_reduce_mask (
		.clk (clk),
		.en  (adv),
		.x   (coeff_s1.mask_coeff),
		.r   (m_s3)
	);

	// modular difference and centered lift
	always_comb begin
		if (r_s3 >= m_s3) begin
			diff = D_W'(r_s3) - D_W'(m_s3);
		end else begin
			diff = D_W'(r_s3) + QV - D_W'(m_s3);
		end
		absv = (diff > HALF) ? (QV - diff) : diff;
	end

	assign a_ext = 16'(a_s4);

	always_ff @(posedge clk) begin
		if (adv) begin
			a_s4    <= A_W'(absv);
			sq_s5   <= SQ_W'(a_s4) * SQ_W'(a_s4);
			amax_s5 <= (a_ext > 16'(rnbc_pkg::MAX_CLAMP)) ? rnbc_pkg::MAX_CLAMP
				: a_ext[rnbc_pkg::INF_W-1:0];
		end
	end

	// accumulate and check
	always_comb begin
		sum_wide = (rnbc_pkg::SUMSQ_W + 1)'(sumsq_q) + (rnbc_pkg::SUMSQ_W + 1)'(sq_s5);
		new_sum  = sum_wide[rnbc_pkg::SUMSQ_W] ? rnbc_pkg::SUMSQ_SAT
			: sum_wide[rnbc_pkg::SUMSQ_W-1:0];
		new_max  = (amax_s5 > max_q) ? amax_s5 : max_q;
		inf_ex   = new_max > inf_bound_q;
		l2_small = new_sum < l2_sq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q   <= '0;
			sumsq_q <= '0;
		end else if (adv && v_s5) begin
			if (last_s5) begin
				max_q   <= '0;
				sumsq_q <= '0;
			end else begin
				max_q   <= new_max;
				sumsq_q <= new_sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv && v_s5 && last_s5) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s5 && last_s5) begin
			result_q.verdict      <= inf_ex | l2_small;
			result_q.inf_exceeded <= inf_ex;
			result_q.l2_too_small <= l2_small;
			result_q.max_abs      <= new_max;
			result_q.sum_squares  <= new_sum;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// streams coefficient pairs into the response norm bound check and compares
// every verdict with a table entry or a local model of the lift, max and
// saturating sum of squares; covers reset values, field extremes, unreduced
// inputs, one-beat vectors, a long full-magnitude vector and several bound
// settings under random idling
// ----------------------------------------------------------------------------
module testbench;

	localparam int MOD         = 3329;
	localparam int SETTLE      = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int FLOOD_LEN   = 120;

	typedef struct packed {
		rnbc_pkg::coeff_t  beat;
		logic              typed;
		rnbc_pkg::result_t want;
	} vector_row_t;

	localparam int N_ROWS = 18;
	localparam vector_row_t DIRECTED_ROWS [N_ROWS] = '{
		'{'{12'd0,    12'd0,    1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 11'd0,    32'd0}},
		'{'{12'd3328, 12'd0,    1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 11'd1,    32'd1}},
		'{'{12'd0,    12'd3328, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 11'd1,    32'd1}},
		'{'{12'd1664, 12'd0,    1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 11'd1664, 32'd2768896}},
		'{'{12'd0,    12'd1664, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 11'd1664, 32'd2768896}},
		'{'{12'd1665, 12'd0,    1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 11'd1664, 32'd2768896}},
		'{'{12'd4095, 12'd0,    1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 11'd766,  32'd586756}},
		'{'{12'd0,    12'd4095, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 11'd766,  32'd586756}},
		'{'{12'd4095, 12'd4095, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 11'd0,    32'd0}},
		'{'{12'd3329, 12'd0,    1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 11'd0,    32'd0}},
		'{'{12'd4095, 12'd3329, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0, 11'd766,  32'd586756}},
		'{'{12'd100,  12'd50,   1'b0}, 1'b0, '0},
		'{'{12'd50,   12'd100,  1'b0}, 1'b0, '0},
		'{'{12'd2000, 12'd10,   1'b0}, 1'b0, '0},
		'{'{12'd4000, 12'd3000, 1'b0}, 1'b0, '0},
		'{'{12'd0,    12'd0,    1'b1}, 1'b0, '0},
		'{'{12'd2730, 12'd1365, 1'b0}, 1'b0, '0},
		'{'{12'd1365, 12'd2730, 1'b1}, 1'b0, '0}
	};

	logic                              clk;
	logic                              arst_n;
	logic                              coeff_valid;
	logic                              coeff_ready;
	rnbc_pkg::coeff_t                  coeff;
	logic                              result_valid;
	logic                              result_ready;
	rnbc_pkg::result_t                 result;
	logic                              psel;
	logic                              penable;
	logic                              pwrite;
	logic [rnbc_pkg::APB_AW-1:0]       paddr;
	logic [rnbc_pkg::APB_DW-1:0]       pwdata;
	logic [rnbc_pkg::APB_DW-1:0]       prdata;
	logic                              pready;

	logic [rnbc_pkg::INF_W-1:0]        run_max;
	logic [rnbc_pkg::SUMSQ_W-1:0]      run_sumsq;
	logic [rnbc_pkg::INF_W-1:0]        cfg_inf_bound;
	logic [rnbc_pkg::L2_W-1:0]         cfg_l2_min;
	rnbc_pkg::result_t                 pending_verdicts [$];
	int                                verdict_errors;
	int                                reg_errors;
	bit                                steady;
	int                                hold_asks;

	response_norm_bound_check #(
		.MODULUS(MOD)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.coeff_valid (coeff_valid),
		.coeff_ready (coeff_ready),
		.coeff       (coeff),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * 1000000);
		$display("FAILED: results differ");
		$finish;
	end

	// fold one beat into the running norms; returns 1 with the verdict on a last beat
	function automatic bit norm_fold(input rnbc_pkg::coeff_t c, output rnbc_pkg::result_t r);
		int unsigned      rv;
		int unsigned      mv;
		int unsigned      d;
		int unsigned      a;
		int unsigned      clamped;
		longint unsigned  sum;
		longint unsigned  min_sq;
		rv = c.resp_coeff;
		mv = c.mask_coeff;
		rv = rv % MOD;
		mv = mv % MOD;
		d = (rv >= mv) ? (rv - mv) : (rv + MOD - mv);
		a = (d > MOD / 2) ? (MOD - d) : d;
		clamped = (a > rnbc_pkg::MAX_CLAMP) ? rnbc_pkg::MAX_CLAMP : a;
		if (clamped > run_max)
			run_max = rnbc_pkg::INF_W'(clamped);
		sum = run_sumsq;
		sum = sum + longint'(a) * longint'(a);
		run_sumsq = (sum > rnbc_pkg::SUMSQ_SAT) ? rnbc_pkg::SUMSQ_SAT
			: rnbc_pkg::SUMSQ_W'(sum);
		r = '0;
		if (!c.last)
			return 1'b0;
		min_sq = cfg_l2_min;
		min_sq = min_sq * min_sq;
		r.inf_exceeded = (run_max > cfg_inf_bound);
		r.l2_too_small = (run_sumsq < min_sq);
		r.verdict = r.inf_exceeded | r.l2_too_small;
		r.max_abs = run_max;
		r.sum_squares = run_sumsq;
		run_max = '0;
		run_sumsq = '0;
		return 1'b1;
	endfunction

	function automatic rnbc_pkg::coeff_t rand_coeff(input bit last);
		rnbc_pkg::coeff_t  c;
		int unsigned       m;
		m = $urandom_range(MOD - 1);
		c.last = last;
		case ($urandom_range(3))
			0: begin
				c.resp_coeff = rnbc_pkg::COEFF_W'($urandom_range(4095));
				c.mask_coeff = rnbc_pkg::COEFF_W'($urandom_range(4095));
			end
			1: begin
				// lifted value right around the half modulus
				c.mask_coeff = rnbc_pkg::COEFF_W'(m);
				c.resp_coeff = rnbc_pkg::COEFF_W'((m + MOD / 2 - 2 + $urandom_range(4)) % MOD);
			end
			2: begin
				c.mask_coeff = rnbc_pkg::COEFF_W'(m);
				c.resp_coeff = rnbc_pkg::COEFF_W'((m + MOD - 20 + $urandom_range(40)) % MOD);
			end
			default: begin
				c.resp_coeff = rnbc_pkg::COEFF_W'($urandom_range(MOD - 1));
				c.mask_coeff = rnbc_pkg::COEFF_W'(m);
			end
		endcase
		return c;
	endfunction

	task automatic push_coeff(input rnbc_pkg::coeff_t c, input logic typed,
		input rnbc_pkg::result_t want);
		rnbc_pkg::result_t  r;
		int                 gap;
		if (!steady && $urandom_range(99) < 13) begin
			coeff_valid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
		coeff_valid <= 1'b1;
		coeff <= c;
		@(posedge clk);
		while (!coeff_ready)
			@(posedge clk);
		if (norm_fold(c, r))
			pending_verdicts.push_back(typed ? want : r);
	endtask

	task automatic drain();
		coeff_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [rnbc_pkg::APB_DW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read(input logic idx, input logic [rnbc_pkg::APB_DW-1:0] want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want) begin
			$error("prdata at %0d: expected %0d, got %0d", idx, want, prdata);
			reg_errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_norm_bounds(input logic [rnbc_pkg::INF_W-1:0] inf,
		input logic [rnbc_pkg::L2_W-1:0] l2);
		reg_write(rnbc_pkg::REG_INF_BOUND, rnbc_pkg::APB_DW'(inf));
		reg_write(rnbc_pkg::REG_L2_MIN, rnbc_pkg::APB_DW'(l2));
		cfg_inf_bound = inf;
		cfg_l2_min = l2;
		reg_read(rnbc_pkg::REG_INF_BOUND, rnbc_pkg::APB_DW'(inf));
		reg_read(rnbc_pkg::REG_L2_MIN, rnbc_pkg::APB_DW'(l2));
	endtask

	task automatic run_vectors(input int n_beats, input bit short_only);
		int sent;
		int len;
		sent = 0;
		while (sent < n_beats) begin
			if (short_only)
				len = $urandom_range(1, 2);
			else if ($urandom_range(9) == 0)
				len = $urandom_range(9, 24);
			else
				len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++)
				push_coeff(rand_coeff(i == len - 1), 1'b0, '0);
			sent += len;
		end
	endtask

	// result side: random backpressure plus one long hold-off on request
	initial begin
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		result_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_ready <= 1'b0;
				hold_left--;
			end else begin
				result_ready <= steady || ($urandom_range(99) >= 13);
			end
		end
	end

	always @(posedge clk) begin
		rnbc_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("result beat with no verdict pending");
				verdict_errors++;
			end else begin
				want = pending_verdicts.pop_front();
				if (result.verdict !== want.verdict) begin
					$error("verdict: expected %0d, got %0d", want.verdict, result.verdict);
					verdict_errors++;
				end
				if (result.inf_exceeded !== want.inf_exceeded) begin
					$error("inf_exceeded: expected %0d, got %0d",
						want.inf_exceeded, result.inf_exceeded);
					verdict_errors++;
				end
				if (result.l2_too_small !== want.l2_too_small) begin
					$error("l2_too_small: expected %0d, got %0d",
						want.l2_too_small, result.l2_too_small);
					verdict_errors++;
				end
				if (result.max_abs !== want.max_abs) begin
					$error("max_abs: expected %0d, got %0d", want.max_abs, result.max_abs);
					verdict_errors++;
				end
				if (result.sum_squares !== want.sum_squares) begin
					$error("sum_squares: expected %0d, got %0d",
						want.sum_squares, result.sum_squares);
					verdict_errors++;
				end
			end
		end
	end

	initial begin
		rnbc_pkg::coeff_t  c;
		int unsigned       m;
		verdict_errors = 0;
		reg_errors = 0;
		steady = 1'b0;
		hold_asks = 0;
		run_max = '0;
		run_sumsq = '0;
		cfg_inf_bound = rnbc_pkg::INF_BOUND_RST;
		cfg_l2_min = rnbc_pkg::L2_MIN_RST;
		arst_n <= 1'b0;
		coeff_valid <= 1'b0;
		coeff <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		reg_read(rnbc_pkg::REG_INF_BOUND, rnbc_pkg::APB_DW'(rnbc_pkg::INF_BOUND_RST));
		reg_read(rnbc_pkg::REG_L2_MIN, rnbc_pkg::APB_DW'(rnbc_pkg::L2_MIN_RST));
		foreach (DIRECTED_ROWS[i])
			push_coeff(DIRECTED_ROWS[i].beat, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
		drain();

		// tightest bounds, every vector fails
		set_norm_bounds(11'd0, 16'd65535);
		run_vectors(80, 1'b0);
		drain();

		// loosest bounds, then a stretch with no idling, then a long result stall
		set_norm_bounds(11'd1664, 16'd0);
		run_vectors(50, 1'b0);
		steady = 1'b1;
		run_vectors(120, 1'b0);
		steady = 1'b0;
		hold_asks++;
		run_vectors(60, 1'b1);
		drain();

		for (int p = 0; p < 3; p++) begin
			set_norm_bounds(rnbc_pkg::INF_W'($urandom_range(1664)),
				rnbc_pkg::L2_W'($urandom_range(8000)));
			run_vectors(40, 1'b0);
			if (p == 1)
				drain();
			run_vectors(50, 1'b0);
			drain();
		end

		// one long vector at full magnitude
		set_norm_bounds(11'd1663, 16'd65535);
		for (int i = 0; i < FLOOD_LEN; i++) begin
			m = $urandom_range(MOD - 1);
			c.mask_coeff = rnbc_pkg::COEFF_W'(m);
			c.resp_coeff = rnbc_pkg::COEFF_W'((m + MOD / 2 + $urandom_range(1)) % MOD);
			c.last = (i == FLOOD_LEN - 1);
			push_coeff(c, 1'b0, '0);
		end
		run_vectors(20, 1'b0);
		drain();

		if (verdict_errors == 0 && reg_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
